/* design/power_stage_cc_cv_regulator_defines.svh */
// Assertion macros for the CC/CV power stage regulator.
// Used by power_stage_cc_cv_regulator.sv; expects clk and arst_n in scope.
`ifndef POWER_STAGE_CC_CV_REGULATOR_DEFINES_SVH
`define POWER_STAGE_CC_CV_REGULATOR_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define PSCC_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("power stage regulator: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define PSCC_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("power stage regulator: next-cycle check failed");

`endif

/* design/pscc_pkg.sv */
// Shared constants and types for the CC/CV power stage regulator.
// No dependencies; referenced by scoped names from the regulator.
package pscc_pkg;

	// Default parameter values.
	localparam int ADC_BITS_DEF  = 12;
	localparam int TICK_BITS_DEF = 16;

	// Field and datapath widths.
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 16;
	localparam int MV_W        = 16;
	localparam int TARGET_MA_W = 13;
	localparam int DAC_W       = 12;
	localparam int Q8_SHIFT    = 8;
	localparam int PROD_W      = TARGET_MA_W + MV_W;
	localparam int DIV_NUM_W   = PROD_W + 1;
	localparam int DIV_DEN_W   = 16;
	localparam int IMA_WIDE_W  = MV_W + 2;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE           = 3'd0,
		REG_ON_TICKS       = 3'd1,
		REG_PERIOD_TICKS   = 3'd2,
		REG_CURRENT_TARGET = 3'd3,
		REG_VOLTAGE_TARGET = 3'd4,
		REG_ZERO_OUTPUT    = 3'd5,
		REG_DIVIDER_RATIO  = 3'd6,
		REG_CURRENT_OFFSET = 3'd7
	} reg_index_t;

	// Sensor scaling: full-scale millivolts and milliamps, and the Hall zero point.
	localparam logic [MV_W-1:0]              VOUT_FULL_MV = 16'd55000;
	localparam logic [MV_W-1:0]              CUR_FULL_MA  = 16'd35640;
	localparam logic signed [IMA_WIDE_W-1:0] CUR_ZERO_MA  = 18'sd27000;
	localparam logic signed [IMA_WIDE_W-1:0] IMA_SAT_MAX  = 18'sd32767;
	localparam logic signed [IMA_WIDE_W-1:0] IMA_SAT_MIN  = -18'sd32768;

	// Regulation limits.
	localparam logic signed [MV_W-1:0] FAULT_MA   = 16'sd6500;
	localparam logic signed [MV_W-1:0] CC_MIN_MA  = 16'sd100;
	localparam logic [MV_W-1:0]        SP_MIN_MV  = 16'd100;
	localparam logic [MV_W-1:0]        SP_MAX_MV  = 16'd40000;
	localparam logic [MV_W-1:0]        SP_FLOOR_MV = 16'd1000;
	localparam logic [DAC_W-1:0]       DAC_MAX    = 12'd3300;

	// Register reset values.
	localparam logic [MV_W-1:0] VOLT_TARGET_RST = 16'd1000;
	localparam logic [MV_W-1:0] ZERO_OUTPUT_RST = 16'd40000;
	localparam logic [MV_W-1:0] RATIO_RST       = 16'd3072;

endpackage

/* design/power_stage_cc_cv_regulator.sv */
// CC/CV power stage regulator: one result per tick item.
// Depends on pscc_pkg and power_stage_cc_cv_regulator_defines.svh.
//
//   channel | handshake               | payload
//   --------+-------------------------+------------------------------------------------
//   cfg     | cfg_write_en            | cfg_index, cfg_data
//   in      | in_valid / in_stall     | vout_sample, current_sample
//   out     | out_valid / out_stall   | output_enable, dac_mv, state_changed,
//           |                         | overcurrent_fault, measured_current_ma,
//           |                         | measured_voltage_mv
//
// A tick's result always passes the bit-serial sample multiplier; with regulation done, voltage mode
// adds the DAC division, and current mode above 100 mA first adds a target multiplication and a
// setpoint division, both divisions running on the shared 30-step restoring divider.
// The next tick is taken in the cycle after the result is loaded into the output register,
// even while that result is still stalled. Reset restores the register defaults and clears
// the timer, fault and DAC state at once, with no sweep.
`include "power_stage_cc_cv_regulator_defines.svh"

module power_stage_cc_cv_regulator #(
	parameter int ADC_BITS  = pscc_pkg::ADC_BITS_DEF,
	parameter int TICK_BITS = pscc_pkg::TICK_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write_en,
	input  logic [pscc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pscc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [ADC_BITS-1:0]                 vout_sample,
	input  logic [ADC_BITS-1:0]                 current_sample,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                output_enable,
	output logic [pscc_pkg::DAC_W-1:0]          dac_mv,
	output logic                                state_changed,
	output logic                                overcurrent_fault,
	output logic signed [pscc_pkg::MV_W-1:0]    measured_current_ma,
	output logic [pscc_pkg::MV_W-1:0]           measured_voltage_mv
);

	localparam int MV_W      = pscc_pkg::MV_W;
	localparam int ACC_W     = ADC_BITS + MV_W;
	localparam int CMP_W     = (TICK_BITS > MV_W) ? TICK_BITS : MV_W;
	localparam int NUM_W     = pscc_pkg::DIV_NUM_W;
	localparam int DEN_W     = pscc_pkg::DIV_DEN_W;
	localparam int PROD_W    = pscc_pkg::PROD_W;
	localparam int TGT_W     = pscc_pkg::TARGET_MA_W;
	localparam int DAC_W     = pscc_pkg::DAC_W;
	localparam int WIDE_W    = pscc_pkg::IMA_WIDE_W;
	localparam int STEP_MAX  = (ADC_BITS > NUM_W) ? ADC_BITS : NUM_W;
	localparam int CNT_W     = $clog2(STEP_MAX);
	localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (ADC_BITS - 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_ADC,
		S_SCALE,
		S_CHECK,
		S_MUL_SP,
		S_SP_PREP,
		S_DIV,
		S_SP_DONE,
		S_DAC_PREP,
		S_DAC_DONE,
		S_FINISH
	} state_t;

	// Configuration registers.
	logic             mode_q;
	logic [MV_W-1:0]  on_ticks_q;
	logic [MV_W-1:0]  period_ticks_q;
	logic [TGT_W-1:0] target_ma_q;
	logic [MV_W-1:0]  zero_out_q;
	logic [MV_W-1:0]  ratio_q;
	logic [MV_W-1:0]  offset_q;

	// Control and regulation state.
	state_t               state_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [TICK_BITS-1:0] elapsed_q;
	logic                 fault_q;
	logic                 prev_fault_q;
	logic [MV_W-1:0]      setpoint_q;
	logic [DAC_W-1:0]     last_dac_q;
	logic                 enable_q;
	logic                 changed_q;
	logic                 div_dac_q;

	// Output register.
	logic                 out_valid_q;
	logic                 out_enable_q;
	logic [DAC_W-1:0]     out_dac_q;
	logic                 out_changed_q;
	logic                 out_fault_q;
	logic [MV_W-1:0]      out_ima_q;
	logic [MV_W-1:0]      out_vmv_q;

	// Serial datapath registers.
	logic [ADC_BITS-1:0]  vraw_q;
	logic [ADC_BITS-1:0]  iraw_q;
	logic [ACC_W-1:0]     acc_v_q;
	logic [ACC_W-1:0]     acc_i_q;
	logic [MV_W-1:0]      vmv_q;
	logic [MV_W-1:0]      ima_q;
	logic [TGT_W-1:0]     target_sh_q;
	logic [PROD_W-1:0]    prod_q;
	logic [NUM_W-1:0]     num_q;
	logic [DEN_W-1:0]     den_q;
	logic [DEN_W-1:0]     rem_q;

	// Combinational helpers.
	logic                     in_xfer;
	logic [TICK_BITS-1:0]     elapsed_eff;
	logic [TICK_BITS-1:0]     elapsed_inc;
	logic [TICK_BITS-1:0]     elapsed_next;
	logic                     enable_now;
	logic [ACC_W-1:0]         v_sum;
	logic [ACC_W-1:0]         i_sum;
	logic signed [WIDE_W-1:0] ima_wide;
	logic [MV_W-1:0]          ima_sat;
	logic                     over_now;
	logic                     cc_active;
	logic [DEN_W:0]           div_shift;
	logic [DEN_W+1:0]         div_diff;
	logic                     div_bit;
	logic [MV_W-1:0]          sp_clamped;
	logic [DEN_W-1:0]         ratio_eff;
	logic [DAC_W-1:0]         dac_sat;

	assign in_stall = (state_q != S_IDLE);
	assign in_xfer  = in_valid && !in_stall;

	// Period timer: restarted when the fault state has moved since the last tick.
	always_comb begin
		elapsed_eff  = (prev_fault_q != fault_q) ? '0 : elapsed_q;
		elapsed_inc  = elapsed_eff + TICK_BITS'(1);
		elapsed_next = (CMP_W'(elapsed_inc) > CMP_W'(period_ticks_q)) ? '0 : elapsed_inc;
		enable_now   = (CMP_W'(elapsed_eff) < CMP_W'(on_ticks_q)) && !fault_q;
	end

	// Rounded scaling of the accumulated products, offset removal and saturation.
	always_comb begin
		v_sum    = acc_v_q + ROUND_HALF;
		i_sum    = acc_i_q + ROUND_HALF;
		ima_wide = $signed({2'b00, i_sum[ACC_W-1 -: MV_W]}) - pscc_pkg::CUR_ZERO_MA
			- $signed({{2{offset_q[MV_W-1]}}, offset_q});
		if (ima_wide > pscc_pkg::IMA_SAT_MAX) begin
			ima_sat = {1'b0, {(MV_W-1){1'b1}}};
		end else if (ima_wide < pscc_pkg::IMA_SAT_MIN) begin
			ima_sat = {1'b1, {(MV_W-1){1'b0}}};
		end else begin
			ima_sat = ima_wide[MV_W-1:0];
		end
		over_now  = $signed(ima_q) > pscc_pkg::FAULT_MA;
		cc_active = $signed(ima_q) > pscc_pkg::CC_MIN_MA;
	end

	// One restoring division step, plus the clamps applied to the quotients.
	always_comb begin
		div_shift = {rem_q, num_q[NUM_W-1]};
		div_diff  = {1'b0, div_shift} - {2'b00, den_q};
		div_bit   = !div_diff[DEN_W+1];
		if (num_q > NUM_W'(pscc_pkg::SP_MAX_MV)) begin
			sp_clamped = pscc_pkg::SP_MAX_MV;
		end else if (num_q < NUM_W'(pscc_pkg::SP_MIN_MV)) begin
			sp_clamped = pscc_pkg::SP_MIN_MV;
		end else begin
			sp_clamped = num_q[MV_W-1:0];
		end
		dac_sat   = (num_q > NUM_W'(pscc_pkg::DAC_MAX)) ? pscc_pkg::DAC_MAX : num_q[DAC_W-1:0];
		ratio_eff = (ratio_q == '0) ? DEN_W'(1) : ratio_q;
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q         <= 1'b0;
			on_ticks_q     <= '0;
			period_ticks_q <= '0;
			target_ma_q    <= '0;
			zero_out_q     <= pscc_pkg::ZERO_OUTPUT_RST;
			ratio_q        <= pscc_pkg::RATIO_RST;
			offset_q       <= '0;
		end else if (cfg_write_en) begin
			case (cfg_index)
				pscc_pkg::REG_MODE:           mode_q         <= cfg_data[0];
				pscc_pkg::REG_ON_TICKS:       on_ticks_q     <= cfg_data;
				pscc_pkg::REG_PERIOD_TICKS:   period_ticks_q <= cfg_data;
				pscc_pkg::REG_CURRENT_TARGET: target_ma_q    <= cfg_data[TGT_W-1:0];
				pscc_pkg::REG_ZERO_OUTPUT:    zero_out_q     <= cfg_data;
				pscc_pkg::REG_DIVIDER_RATIO:  ratio_q        <= cfg_data;
				pscc_pkg::REG_CURRENT_OFFSET: offset_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer: tick state, regulation state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			cnt_q         <= '0;
			elapsed_q     <= '0;
			fault_q       <= 1'b0;
			prev_fault_q  <= 1'b0;
			setpoint_q    <= pscc_pkg::VOLT_TARGET_RST;
			last_dac_q    <= '0;
			enable_q      <= 1'b0;
			changed_q     <= 1'b0;
			div_dac_q     <= 1'b0;
			out_valid_q   <= 1'b0;
			out_enable_q  <= 1'b0;
			out_dac_q     <= '0;
			out_changed_q <= 1'b0;
			out_fault_q   <= 1'b0;
			out_ima_q     <= '0;
			out_vmv_q     <= '0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						cnt_q        <= '0;
						prev_fault_q <= fault_q;
						changed_q    <= (prev_fault_q != fault_q);
						enable_q     <= enable_now;
						elapsed_q    <= elapsed_next;
						state_q      <= S_MUL_ADC;
					end
				end
				S_MUL_ADC: begin
					if (cnt_q == CNT_W'(ADC_BITS - 1)) begin
						cnt_q   <= '0;
						state_q <= S_SCALE;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_SCALE: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					if (over_now) begin
						fault_q <= 1'b1;
					end
					if (!enable_q || over_now) begin
						state_q <= S_FINISH;
					end else if (mode_q && cc_active) begin
						state_q <= S_MUL_SP;
					end else begin
						if (mode_q && (setpoint_q < pscc_pkg::SP_FLOOR_MV)) begin
							setpoint_q <= pscc_pkg::SP_FLOOR_MV;
						end
						state_q <= S_DAC_PREP;
					end
				end
				S_MUL_SP: begin
					if (cnt_q == CNT_W'(TGT_W - 1)) begin
						cnt_q   <= '0;
						state_q <= S_SP_PREP;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_SP_PREP: begin
					div_dac_q <= 1'b0;
					state_q   <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q == CNT_W'(NUM_W - 1)) begin
						cnt_q   <= '0;
						state_q <= div_dac_q ? S_DAC_DONE : S_SP_DONE;
					end else begin
						cnt_q <= cnt_q + CNT_W'(1);
					end
				end
				S_SP_DONE: begin
					setpoint_q <= sp_clamped;
					state_q    <= S_DAC_PREP;
				end
				S_DAC_PREP: begin
					if (zero_out_q > setpoint_q) begin
						div_dac_q <= 1'b1;
						state_q   <= S_DIV;
					end else begin
						last_dac_q <= '0;
						state_q    <= S_FINISH;
					end
				end
				S_DAC_DONE: begin
					last_dac_q <= dac_sat;
					state_q    <= S_FINISH;
				end
				S_FINISH: begin
					// Load the result once the output register is free or being drained.
					if (!out_valid_q || !out_stall) begin
						out_valid_q   <= 1'b1;
						out_enable_q  <= enable_q;
						out_dac_q     <= last_dac_q;
						out_changed_q <= changed_q;
						out_fault_q   <= fault_q;
						out_ima_q     <= ima_q;
						out_vmv_q     <= vmv_q;
						state_q       <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			// A voltage target write also loads the working setpoint.
			if (cfg_write_en && (cfg_index == pscc_pkg::REG_VOLTAGE_TARGET)) begin
				setpoint_q <= cfg_data;
			end
		end
	end

	// Serial datapath: bit-serial multipliers and the restoring divider.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					vraw_q  <= vout_sample;
					iraw_q  <= current_sample;
					acc_v_q <= '0;
					acc_i_q <= '0;
				end
			end
			S_MUL_ADC: begin
				// Most significant sample bit first: shift and conditionally add the scale.
				acc_v_q <= {acc_v_q[ACC_W-2:0], 1'b0}
					+ (vraw_q[ADC_BITS-1] ? ACC_W'(pscc_pkg::VOUT_FULL_MV) : '0);
				acc_i_q <= {acc_i_q[ACC_W-2:0], 1'b0}
					+ (iraw_q[ADC_BITS-1] ? ACC_W'(pscc_pkg::CUR_FULL_MA) : '0);
				vraw_q  <= {vraw_q[ADC_BITS-2:0], 1'b0};
				iraw_q  <= {iraw_q[ADC_BITS-2:0], 1'b0};
			end
			S_SCALE: begin
				vmv_q       <= v_sum[ACC_W-1 -: MV_W];
				ima_q       <= ima_sat;
				prod_q      <= '0;
				target_sh_q <= target_ma_q;
			end
			S_MUL_SP: begin
				prod_q      <= {prod_q[PROD_W-2:0], 1'b0}
					+ (target_sh_q[TGT_W-1] ? PROD_W'(vmv_q) : '0);
				target_sh_q <= {target_sh_q[TGT_W-2:0], 1'b0};
			end
			S_SP_PREP: begin
				// Target times voltage plus half the current, for a rounded quotient.
				num_q <= NUM_W'(prod_q) + NUM_W'(ima_q[MV_W-1:1]);
				den_q <= ima_q;
				rem_q <= '0;
			end
			S_DIV: begin
				rem_q <= div_bit ? div_diff[DEN_W-1:0] : div_shift[DEN_W-1:0];
				num_q <= {num_q[NUM_W-2:0], div_bit};
			end
			S_DAC_PREP: begin
				// Headroom in Q8 plus half the ratio, for a rounded quotient.
				num_q <= NUM_W'({zero_out_q - setpoint_q, {pscc_pkg::Q8_SHIFT{1'b0}}})
					+ NUM_W'(ratio_eff[DEN_W-1:1]);
				den_q <= ratio_eff;
				rem_q <= '0;
			end
			default: ;
		endcase
	end

	assign out_valid           = out_valid_q;
	assign output_enable       = out_enable_q;
	assign dac_mv              = out_dac_q;
	assign state_changed       = out_changed_q;
	assign overcurrent_fault   = out_fault_q;
	assign measured_current_ma = out_ima_q;
	assign measured_voltage_mv = out_vmv_q;

	// Checks on the sequencer and datapath.
	`PSCC_ASSERT_IMPL(a_dac_in_range, out_valid_q, out_dac_q <= pscc_pkg::DAC_MAX)
	`PSCC_ASSERT_NEXT(a_fault_sticky, fault_q, fault_q)
	`PSCC_ASSERT_IMPL(a_change_disables, out_valid_q && out_changed_q, !out_enable_q)
	`PSCC_ASSERT_IMPL(a_div_remainder, state_q == S_DIV, rem_q < den_q)

endmodule
